// File: sv/dtc_pkg.sv
// Shared types, constants and the encoder step table of the dose timer controller.
`default_nettype none
package dtc_pkg;

  localparam int unsigned PosW   = 16;
  localparam int unsigned ShownW = 15;
  localparam int unsigned CntW   = 7;

  localparam logic [CntW-1:0] ArmLimit  = CntW'(2);
  localparam logic [CntW-1:0] LockLimit = CntW'(5);

  typedef enum logic [1:0] {
    ACT_ENCODER   = 2'd0,
    ACT_BUTTONS   = 2'd1,
    ACT_SERVICE   = 2'd2,
    ACT_COUNTDOWN = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    DIR_NONE,
    DIR_FWD,
    DIR_BACK
  } dir_e;

  typedef struct packed {
    action_e action;
    logic    enc_a;
    logic    enc_b;
    logic    start_level;
    logic    power_level;
  } tick_t;

  typedef struct packed {
    logic              busy_res;
    logic              display_off;
    logic [ShownW-1:0] shown_value;
    logic              load_on;
  } result_t;

  typedef struct packed {
    logic scan;
    logic pressed;
    logic take;
    logic lock;
  } btn_ctrl_t;

  // Forward phase sequence is 0, 2, 3, 1, 0.
  function automatic dir_e enc_dir(input logic [1:0] old_ph, input logic [1:0] new_ph);
    dir_e d;
    d = DIR_NONE;
    case ({old_ph, new_ph})
      4'b00_10, 4'b10_11, 4'b11_01, 4'b01_00: d = DIR_FWD;
      4'b10_00, 4'b11_10, 4'b01_11, 4'b00_01: d = DIR_BACK;
      default:                                d = DIR_NONE;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// File: sv/dtc_button.sv
// Debounce counter, lockout and pending flag of one active-low button.
`default_nettype none
module dtc_button
  import dtc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire btn_ctrl_t ctrl_i,
  output logic           pending_o
);

  logic            armed_q, armed_d;
  logic            lock_q, lock_d;
  logic            pend_q, pend_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] cnt_inc;

  assign cnt_inc = cnt_q + CntW'(1);

  always_comb begin
    armed_d = armed_q;
    lock_d  = lock_q;
    pend_d  = pend_q;
    cnt_d   = cnt_q;
    if (ctrl_i.scan) begin
      if (!lock_q) begin
        if (armed_q) begin
          if (ctrl_i.pressed) begin
            cnt_d = cnt_inc;
          end else if (cnt_q > ArmLimit) begin
            armed_d = 1'b0;
            cnt_d   = '0;
            pend_d  = 1'b1;
          end
        end else if (ctrl_i.pressed) begin
          armed_d = 1'b1;
        end
      end else begin
        cnt_d = cnt_inc;
        if (cnt_inc > LockLimit) begin
          lock_d = 1'b0;
          cnt_d  = '0;
        end
      end
    end
    if (ctrl_i.take) begin
      pend_d = 1'b0;
    end
    if (ctrl_i.lock) begin
      lock_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      lock_q  <= 1'b0;
      pend_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      armed_q <= armed_d;
      lock_q  <= lock_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
    end
  end

  assign pending_o = pend_q;

endmodule
`default_nettype wire

// File: sv/dtc_core.sv
// Timer state, encoder position, countdown and the result register.
`default_nettype none
module dtc_core
  import dtc_pkg::*;
#(
  parameter int unsigned DEFAULT_TIME = 62
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  step_i,
  input  wire tick_t tick_i,
  output result_t    result_o
);

  logic [1:0]        phase_q, phase_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [PosW-1:0]   rem_q, rem_d;
  logic              run_q, run_d;
  logic              enc_lock_q, enc_lock_d;
  logic              off_q, off_d;
  logic              load_q, load_d;
  logic [ShownW-1:0] shown_q, shown_d;
  result_t           res_q;

  logic      start_pend, power_pend;
  logic      is_service;
  btn_ctrl_t start_ctrl, power_ctrl;
  logic [1:0] new_phase;
  dir_e      dir;

  assign is_service = step_i && (tick_i.action == ACT_SERVICE);

  always_comb begin
    start_ctrl.scan    = step_i && (tick_i.action == ACT_BUTTONS) && !off_q;
    start_ctrl.pressed = !tick_i.start_level;
    start_ctrl.take    = is_service;
    start_ctrl.lock    = 1'b0;
    power_ctrl.scan    = step_i && (tick_i.action == ACT_BUTTONS);
    power_ctrl.pressed = !tick_i.power_level;
    power_ctrl.take    = is_service;
    power_ctrl.lock    = is_service && (start_pend || power_pend);
  end

  dtc_button u_start_btn (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (start_ctrl),
    .pending_o (start_pend)
  );

  dtc_button u_power_btn (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (power_ctrl),
    .pending_o (power_pend)
  );

  assign new_phase = {tick_i.enc_a, tick_i.enc_b};
  assign dir       = enc_dir(phase_q, new_phase);

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    rem_d      = rem_q;
    run_d      = run_q;
    enc_lock_d = enc_lock_q;
    off_d      = off_q;
    load_d     = load_q;
    shown_d    = shown_q;
    if (step_i) begin
      case (tick_i.action)
        ACT_ENCODER: begin
          if (!(off_q || enc_lock_q)) begin
            case (dir)
              DIR_FWD:  pos_d = pos_q + PosW'(1);
              DIR_BACK: pos_d = pos_q - PosW'(1);
              default:  pos_d = pos_q;
            endcase
            phase_d = new_phase;
            shown_d = pos_d[PosW-1:1];
          end
        end
        ACT_SERVICE: begin
          if (start_pend) begin
            rem_d = {1'b0, pos_q[PosW-1:1]};
            run_d = 1'b1;
          end
          if (power_pend) begin
            off_d = !off_q;
          end
        end
        ACT_COUNTDOWN: begin
          if (run_q) begin
            if (rem_q != '0) begin
              enc_lock_d = 1'b1;
              rem_d      = rem_q - PosW'(1);
              shown_d    = rem_d[ShownW-1:0];
              load_d     = 1'b1;
            end else begin
              enc_lock_d = 1'b0;
              run_d      = 1'b0;
              load_d     = 1'b0;
              shown_d    = pos_q[PosW-1:1];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= '0;
      pos_q      <= PosW'(2 * DEFAULT_TIME);
      rem_q      <= PosW'(DEFAULT_TIME);
      run_q      <= 1'b0;
      enc_lock_q <= 1'b0;
      off_q      <= 1'b0;
      load_q     <= 1'b0;
      shown_q    <= ShownW'(DEFAULT_TIME);
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      rem_q      <= rem_d;
      run_q      <= run_d;
      enc_lock_q <= enc_lock_d;
      off_q      <= off_d;
      load_q     <= load_d;
      shown_q    <= shown_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      res_q.load_on     <= load_d;
      res_q.shown_value <= shown_d;
      res_q.display_off <= off_d;
      res_q.busy_res    <= run_d;
    end
  end

  assign result_o = res_q;

endmodule
`default_nettype wire

// File: sv/dose_timer_controller.sv
// Top level of the dose timer controller: stream ports, tick register and result handshake.
`default_nettype none
// The block takes one tick transaction per cycle and returns exactly one result
// transaction for each, in order. A tick passes an input register and is applied to
// the timer state once the output register can take its result; the new state and
// the result are registered together, and the throughput is one transaction per cycle
// as long as the output side keeps tready high; the state update sets that rate.
// The tick kind travels in s_axis_tuser; the result reports the load drive, the
// shown number, the off state and whether a countdown run is active.
module dose_timer_controller
  import dtc_pkg::*;
#(
  parameter int unsigned DEFAULT_TIME = 62
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [0] enc_a, [1] enc_b, [2] start_level, [3] power_level, [7:4] zero
  input  wire logic [7:0]  s_axis_tdata,
  // [1:0] action
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] load_on, [15:1] shown_value, [16] display_off, [17] busy_res, [23:18] zero
  output logic [23:0]      m_axis_tdata
);

  logic    in_valid_q;
  tick_t   in_tick_q;
  logic    out_valid_q;
  logic    advance;
  result_t result;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_tick_q.action      <= action_e'(s_axis_tuser);
      in_tick_q.enc_a       <= s_axis_tdata[0];
      in_tick_q.enc_b       <= s_axis_tdata[1];
      in_tick_q.start_level <= s_axis_tdata[2];
      in_tick_q.power_level <= s_axis_tdata[3];
    end
  end

  dtc_core #(
    .DEFAULT_TIME (DEFAULT_TIME)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .tick_i   (in_tick_q),
    .result_o (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, result.busy_res, result.display_off,
                          result.shown_value, result.load_on};

  a_load_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && result.load_on |-> result.busy_res)
    else $error("load driven without an active run");

  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("applied tick produced no result");

  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |-> !s_axis_tready)
    else $error("input taken while tick register is stalled");

  a_stalled_tick_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_tick_q))
    else $error("stalled tick lost or changed");

endmodule
`default_nettype wire

// File: tb/sv/dose_timer_controller_tb.sv
// Self-checking testbench for the dose timer controller: directed table, random sequences.
`default_nettype none
module dose_timer_controller_tb
  import dtc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DefaultTime = 62;
  localparam logic [6:0]  PressMin    = 7'd2;
  localparam logic [6:0]  LockTicks   = 7'd5;
  localparam int unsigned LongHold    = 60;
  localparam int unsigned QuietLimit  = 1000;
  localparam int unsigned StageItems  = 85;

  localparam result_t IdleReading = '{busy_res: 1'b0, display_off: 1'b0,
                                      shown_value: 15'(DefaultTime), load_on: 1'b0};

  typedef struct packed {
    tick_t   tick;
    logic    typed;
    result_t want;
  } script_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  dose_timer_controller #(.DEFAULT_TIME(DefaultTime)) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Timer state as the testbench expects it.
  logic [1:0]  enc_ph;
  logic [15:0] dial_pos;
  logic [15:0] ticks_left;
  logic        run_active;
  logic        dial_frozen;
  logic        is_off;
  logic        load_drive;
  logic [14:0] disp_num;
  logic        btn_arm  [2];
  logic [6:0]  btn_cnt  [2];
  logic        btn_lock [2];
  logic        btn_req  [2];

  result_t     readings_due [$];
  logic [1:0]  pin_ph = 2'd0;
  int          src_idle_pct   = 0;
  int          sink_stall_pct = 0;
  int          hold_off_asks  = 0;
  int          items_sent     = 0;
  int          results_seen   = 0;
  int          errors         = 0;
  int          seq_count      = 0;
  int          runs_started   = 0;
  int          runs_done      = 0;
  int          off_toggles    = 0;
  int          top_shown      = 0;

  function automatic logic [1:0] fwd_of(input logic [1:0] p);
    case (p)
      2'd0:    return 2'd2;
      2'd2:    return 2'd3;
      2'd3:    return 2'd1;
      default: return 2'd0;
    endcase
  endfunction

  function automatic tick_t make_tick(input action_e act, input bit a, input bit b,
                                      input bit st, input bit pw);
    tick_t t;
    t.action      = act;
    t.enc_a       = a;
    t.enc_b       = b;
    t.start_level = st;
    t.power_level = pw;
    return t;
  endfunction

  function automatic tick_t any_tick();
    return make_tick(action_e'($urandom_range(3)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
  endfunction

  function automatic script_row_t row(input action_e act, input bit a, input bit b,
                                      input bit st, input bit pw, input bit typed = 1'b0,
                                      input result_t want = '0);
    script_row_t r;
    r.tick  = make_tick(act, a, b, st, pw);
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  task automatic reset_timer();
    enc_ph      = 2'd0;
    dial_pos    = 16'(2 * DefaultTime);
    ticks_left  = 16'(DefaultTime);
    run_active  = 1'b0;
    dial_frozen = 1'b0;
    is_off      = 1'b0;
    load_drive  = 1'b0;
    disp_num    = 15'(DefaultTime);
    for (int k = 0; k < 2; k++) begin
      btn_arm[k]  = 1'b0;
      btn_cnt[k]  = '0;
      btn_lock[k] = 1'b0;
      btn_req[k]  = 1'b0;
    end
  endtask

  task automatic debounce(input int k, input bit pressed);
    if (!btn_lock[k]) begin
      if (btn_arm[k]) begin
        if (pressed) begin
          btn_cnt[k] = btn_cnt[k] + 7'd1;
        end else if (btn_cnt[k] > PressMin) begin
          btn_arm[k] = 1'b0;
          btn_cnt[k] = '0;
          btn_req[k] = 1'b1;
        end
      end else if (pressed) begin
        btn_arm[k] = 1'b1;
      end
    end else begin
      btn_cnt[k] = btn_cnt[k] + 7'd1;
    end
    if (btn_lock[k] && btn_cnt[k] > LockTicks) begin
      btn_lock[k] = 1'b0;
      btn_cnt[k]  = '0;
    end
  endtask

  task automatic apply_tick(input tick_t t, output result_t r);
    logic [1:0] nph;
    case (t.action)
      ACT_ENCODER: begin
        if (!(is_off || dial_frozen)) begin
          nph = {t.enc_a, t.enc_b};
          if (nph == fwd_of(enc_ph)) begin
            dial_pos = dial_pos + 16'd1;
          end else if (enc_ph == fwd_of(nph)) begin
            dial_pos = dial_pos - 16'd1;
          end
          enc_ph   = nph;
          disp_num = dial_pos[15:1];
        end
      end
      ACT_BUTTONS: begin
        if (!is_off) begin
          debounce(0, !t.start_level);
        end
        debounce(1, !t.power_level);
      end
      ACT_SERVICE: begin
        if (btn_req[0]) begin
          btn_req[0]  = 1'b0;
          btn_lock[1] = 1'b1;
          ticks_left  = {1'b0, dial_pos[15:1]};
          run_active  = 1'b1;
          runs_started++;
        end
        if (btn_req[1]) begin
          btn_lock[1] = 1'b1;
          btn_req[1]  = 1'b0;
          is_off      = !is_off;
          off_toggles++;
        end
      end
      default: begin
        if (run_active) begin
          dial_frozen = 1'b1;
          if (ticks_left != 16'd0) begin
            ticks_left = ticks_left - 16'd1;
            disp_num   = ticks_left[14:0];
            load_drive = 1'b1;
          end else begin
            run_active  = 1'b0;
            load_drive  = 1'b0;
            disp_num    = dial_pos[15:1];
            dial_frozen = 1'b0;
            runs_done++;
          end
        end
      end
    endcase
    r.busy_res    = run_active;
    r.display_off = is_off;
    r.shown_value = disp_num;
    r.load_on     = load_drive;
  endtask

  task automatic offer_tick(input tick_t t, input bit typed = 1'b0, input result_t want = '0);
    result_t r;
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, t.power_level, t.start_level, t.enc_b, t.enc_a};
    s_axis_tuser  <= t.action;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    apply_tick(t, r);
    readings_due.push_back(typed ? want : r);
    items_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (readings_due.size() != 0);
  endtask

  task automatic turn_dial(input int steps, input bit fwd, input int glitch_pct);
    for (int i = 0; i < steps; i++) begin
      if ($urandom_range(99) < glitch_pct) begin
        pin_ph = 2'($urandom_range(3));
      end else begin
        pin_ph = fwd ? fwd_of(pin_ph) : fwd_of(fwd_of(fwd_of(pin_ph)));
      end
      offer_tick(make_tick(ACT_ENCODER, pin_ph[1], pin_ph[0], 1'($urandom_range(1)),
                           1'($urandom_range(1))));
    end
  endtask

  task automatic press_button(input int k, input int hold);
    for (int i = 0; i <= hold; i++) begin
      bit down;
      down = (i < hold);
      offer_tick(make_tick(ACT_BUTTONS, 1'($urandom_range(1)), 1'($urandom_range(1)),
                           (k == 0 && down) ? 1'b0 : ($urandom_range(7) != 0),
                           (k == 1 && down) ? 1'b0 : ($urandom_range(7) != 0)));
    end
    if ($urandom_range(9) != 0) begin
      offer_tick(make_tick(ACT_SERVICE, 1'($urandom_range(1)), 1'($urandom_range(1)),
                           1'($urandom_range(1)), 1'($urandom_range(1))));
    end
  endtask

  task automatic run_countdown(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        offer_tick(any_tick());
      end else begin
        offer_tick(make_tick(ACT_COUNTDOWN, 1'($urandom_range(1)), 1'($urandom_range(1)),
                             1'($urandom_range(1)), 1'($urandom_range(1))));
      end
    end
  endtask

  task automatic play_sequence();
    int pick;
    pick = $urandom_range(99);
    seq_count++;
    if (seq_count == 9) begin
      press_button(0, 140);
    end else if (pick < 25) begin
      turn_dial($urandom_range(1, 20), 1'($urandom_range(1)), 8);
    end else if (pick < 50) begin
      press_button(0, $urandom_range(1, 9));
    end else if (pick < 62) begin
      press_button(1, $urandom_range(1, 9));
    end else if (pick < 90) begin
      run_countdown($urandom_range(1, 70));
    end else begin
      repeat ($urandom_range(1, 6)) offer_tick(any_tick());
    end
  endtask

  task automatic flag_field(input string field, input int unsigned want_v,
                            input int unsigned got_v);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
    errors++;
  endtask

  // Receiver side: random stalls plus an occasional long hold-off on request.
  initial begin
    int hold_left;
    int served;
    hold_left = 0;
    served    = 0;
    forever begin
      @(posedge clk_i);
      if (served != hold_off_asks) begin
        served    = hold_off_asks;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Result checking and the quiet-cycle watchdog.
  int quiet = 0;
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[17:0]);
      results_seen++;
      if (int'(got.shown_value) > top_shown) begin
        top_shown = int'(got.shown_value);
      end
      if (readings_due.size() == 0) begin
        $display("%0t: result transaction with nothing expected, got %h", $time, got);
        errors++;
      end else begin
        want = readings_due.pop_front();
        if (got.load_on !== want.load_on) begin
          flag_field("load_on", 32'(want.load_on), 32'(got.load_on));
        end
        if (got.shown_value !== want.shown_value) begin
          flag_field("shown_value", 32'(want.shown_value), 32'(got.shown_value));
        end
        if (got.display_off !== want.display_off) begin
          flag_field("display_off", 32'(want.display_off), 32'(got.display_off));
        end
        if (got.busy_res !== want.busy_res) begin
          flag_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
        end
      end
    end
    if (quiet >= QuietLimit) begin
      $display("%0t: timeout, no transaction for %0d cycles", $time, QuietLimit);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    script_row_t script [$];
    script = '{
      row(ACT_ENCODER,   1'b0, 1'b0, 1'b1, 1'b1, 1'b1, IdleReading),
      row(ACT_COUNTDOWN, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, IdleReading),
      row(ACT_SERVICE,   1'b0, 1'b0, 1'b1, 1'b1, 1'b1, IdleReading),
      row(ACT_ENCODER,   1'b1, 1'b0, 1'b1, 1'b1),
      row(ACT_ENCODER,   1'b1, 1'b1, 1'b0, 1'b0),
      row(ACT_ENCODER,   1'b0, 1'b0, 1'b1, 1'b1),
      row(ACT_ENCODER,   1'b0, 1'b1, 1'b1, 1'b1),
      row(ACT_BUTTONS,   1'b0, 1'b0, 1'b0, 1'b1),
      row(ACT_BUTTONS,   1'b1, 1'b1, 1'b0, 1'b1),
      row(ACT_BUTTONS,   1'b0, 1'b0, 1'b0, 1'b1),
      row(ACT_BUTTONS,   1'b1, 1'b1, 1'b0, 1'b1),
      row(ACT_BUTTONS,   1'b0, 1'b0, 1'b1, 1'b1),
      row(ACT_SERVICE,   1'b0, 1'b0, 1'b1, 1'b1),
      row(ACT_COUNTDOWN, 1'b0, 1'b0, 1'b0, 1'b0),
      row(ACT_ENCODER,   1'b1, 1'b1, 1'b1, 1'b1),
      row(ACT_BUTTONS,   1'b0, 1'b0, 1'b0, 1'b1),
      row(ACT_BUTTONS,   1'b0, 1'b0, 1'b0, 1'b1),
      row(ACT_BUTTONS,   1'b0, 1'b0, 1'b0, 1'b1),
      row(ACT_BUTTONS,   1'b0, 1'b0, 1'b0, 1'b1),
      row(ACT_BUTTONS,   1'b0, 1'b0, 1'b1, 1'b1),
      row(ACT_SERVICE,   1'b1, 1'b1, 1'b1, 1'b1),
      row(ACT_COUNTDOWN, 1'b1, 1'b1, 1'b1, 1'b1),
      row(ACT_BUTTONS,   1'b0, 1'b0, 1'b1, 1'b1),
      row(ACT_BUTTONS,   1'b0, 1'b0, 1'b1, 1'b0)
    };
    reset_timer();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      offer_tick(script[i].tick, script[i].typed, script[i].want);
    end
    settle();

    for (int stage = 0; stage < 4; stage++) begin
      case (stage)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 76; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 76; end
        default: begin src_idle_pct = 32; sink_stall_pct = 32; end
      endcase
      if (stage == 0) begin
        hold_off_asks++;
      end
      while (items_sent < script.size() + (stage + 1) * StageItems) begin
        play_sequence();
      end
      settle();
    end

    // Wind the dial below zero so that the shown number reaches its top range.
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    repeat (4) begin
      if (is_off) begin
        press_button(1, 12);
      end
    end
    for (int i = 0; run_active && i < 200; i++) begin
      offer_tick(make_tick(ACT_COUNTDOWN, 1'b0, 1'b0, 1'b1, 1'b1));
    end
    pin_ph = enc_ph;
    turn_dial((dial_pos < 16'd1000) ? int'(dial_pos) + 4 : 4, 1'b0, 0);
    press_button(0, 4);
    run_countdown(5);
    settle();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d tick transactions, checked %0d results, highest shown value %0d.",
             items_sent, results_seen, top_shown);
    $display("Runs started %0d, runs finished %0d, power toggles %0d.",
             runs_started, runs_done, off_toggles);
    if (errors == 0 && readings_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
